// ===== rtl/afg_pkg.sv =====
// Shared types, widths and codes of the audio frame FIFO with gain.
`default_nettype none

package afg_pkg;

  // Store geometry
  localparam int FRAME_DEPTH  = 1024;
  localparam int MAX_CHANNELS = 2;
  localparam int MAX_BURST    = 64;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 14;
  localparam int OP_W     = 3;
  localparam int COUNT_W  = 7;
  localparam int FILL_W   = 11;
  localparam int STATUS_W = 2;
  localparam int CHAN_W   = 2;

  // Derived widths
  localparam int PTR_W  = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int WORD_W = MAX_CHANNELS * SAMPLE_W;

  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [WORD_W-1:0]          word_t;

  // Operation codes of a request
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_ZERO  = 3'd2,
    OP_SCALE = 3'd3,
    OP_PAN   = 3'd4,
    OP_FLUSH = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_OVF   = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ZERO,
    S_POP_RD,
    S_POP_OUT,
    S_WALK,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/afg_req_if.sv =====
// Request channel of the audio frame FIFO: operation and its operands.
`default_nettype none

interface afg_req_if;
  logic                        valid;
  logic                        ready;
  logic [afg_pkg::OP_W-1:0]    operation;
  afg_pkg::sample_t            sample_0;
  afg_pkg::sample_t            sample_1;
  logic [afg_pkg::COUNT_W-1:0] frame_count;
  afg_pkg::gain_t              gain_left;
  afg_pkg::gain_t              gain_right;

  modport source (
    output valid, operation, sample_0, sample_1, frame_count, gain_left, gain_right,
    input  ready
  );
  modport sink (
    input  valid, operation, sample_0, sample_1, frame_count, gain_left, gain_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/afg_rsp_if.sv =====
// Result channel of the audio frame FIFO: popped frame, status and fill level.
`default_nettype none

interface afg_rsp_if;
  logic                         valid;
  logic                         ready;
  afg_pkg::sample_t             out_sample_0;
  afg_pkg::sample_t             out_sample_1;
  logic [afg_pkg::STATUS_W-1:0] status;
  logic                         last;
  logic [afg_pkg::FILL_W-1:0]   fill_level;

  modport source (
    output valid, out_sample_0, out_sample_1, status, last, fill_level,
    input  ready
  );
  modport sink (
    input  valid, out_sample_0, out_sample_1, status, last, fill_level,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/afg_gain.sv =====
// One gain lane: registered Q1.23 x Q2.14 product, then round half up and saturate.
`default_nettype none

module afg_gain (
  input  wire logic             clk_i,
  input  wire afg_pkg::sample_t sample_i,
  input  wire afg_pkg::gain_t   gain_i,
  output afg_pkg::sample_t      sample_o
);

  localparam int RND_W = afg_pkg::PROD_W + 1;
  localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(2 ** (afg_pkg::FRAC_W - 1));
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(2 ** (afg_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(2 ** (afg_pkg::SAMPLE_W - 1));

  logic signed [afg_pkg::PROD_W-1:0] sample_x;
  logic signed [afg_pkg::PROD_W-1:0] gain_x;
  logic signed [afg_pkg::PROD_W-1:0] prod_d;
  logic signed [afg_pkg::PROD_W-1:0] prod_q;
  logic signed [RND_W-1:0]           rnd;
  logic signed [RND_W-1:0]           shifted;

  // Multiply, one register stage
  assign sample_x = afg_pkg::PROD_W'(sample_i);
  assign gain_x   = afg_pkg::PROD_W'(gain_i);
  assign prod_d   = sample_x * gain_x;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Round half up, floor shift, clamp to Q1.23
  assign rnd     = RND_W'(prod_q) + ROUND_BIAS;
  assign shifted = rnd >>> afg_pkg::FRAC_W;

  always_comb begin
    if (shifted > SAT_HI) begin
      sample_o = SAT_HI[afg_pkg::SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      sample_o = SAT_LO[afg_pkg::SAMPLE_W-1:0];
    end else begin
      sample_o = shifted[afg_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/audio_frame_fifo_with_gain_core.sv =====
// Push, flush, rejected or empty requests go to S_RESP; the result loads when the output is free.
// Pop of N frames: per frame, a store read (S_POP_RD), then an output load once the output is free.
// Zero push writes N zero frames at the tail; scale and pan walk the held frames, one frame per
// cycle through the store's single read port and the two-stage gain pipeline.
// One request is in flight at a time; a new one is taken while the last result waits.
// Reset clears pointers and fill count, sets channel register to 2; the frame store is not cleared.
`default_nettype none

module audio_frame_fifo_with_gain_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [afg_pkg::CHAN_W-1:0]  cfg_wdata_i,
  afg_req_if.sink                          req_i,
  afg_rsp_if.source                        rsp_o
);

  // Frame store: both lanes of a frame in one word
  afg_pkg::word_t mem [afg_pkg::FRAME_DEPTH];
  afg_pkg::word_t rdata_q;
  logic           mem_we;
  afg_pkg::ptr_t  mem_waddr;
  afg_pkg::word_t mem_wdata;
  logic           mem_re;
  afg_pkg::ptr_t  mem_raddr;

  // Control state
  afg_pkg::state_e             state_q, state_d;
  logic [afg_pkg::CHAN_W-1:0]  chan_q;
  afg_pkg::ptr_t               rp_q;
  afg_pkg::cnt_t               held_q;
  afg_pkg::cnt_t               cnt_q;
  afg_pkg::ptr_t               addr_q;
  afg_pkg::status_e            status_q;
  afg_pkg::gain_t              gain0_q, gain1_q;
  logic                        lane1_en_q;

  // Walk pipeline
  logic           rd_v_q, prod_v_q;
  afg_pkg::ptr_t  a1_q, a2_q;
  afg_pkg::word_t old_q;
  afg_pkg::sample_t g0, g1;

  // Result register
  logic                           rsp_valid_q;
  afg_pkg::sample_t               rsp_s0_q, rsp_s1_q;
  logic [afg_pkg::STATUS_W-1:0]   rsp_status_q;
  logic                           rsp_last_q;
  logic [afg_pkg::FILL_W-1:0]     rsp_fill_q;
  logic                           out_load;
  afg_pkg::sample_t               out_s0, out_s1;
  afg_pkg::status_e               out_status;
  logic                           out_last;

  // Request decode
  logic                         acc;
  logic                         out_free;
  logic                         two_lanes;
  logic                         full;
  logic [afg_pkg::CMP_W-1:0]    n_ext, held_ext;
  logic                         pop_bad, zero_bad;
  afg_pkg::ptr_t                push_slot;
  afg_pkg::ptr_t                pop_end;

  function automatic afg_pkg::ptr_t wrap_add(afg_pkg::ptr_t base, afg_pkg::cnt_t off);
    logic [afg_pkg::PTR_W:0] sum;
    sum = (afg_pkg::PTR_W + 1)'(base) + (afg_pkg::PTR_W + 1)'(off);
    if (sum >= (afg_pkg::PTR_W + 1)'(afg_pkg::FRAME_DEPTH)) begin
      sum = sum - (afg_pkg::PTR_W + 1)'(afg_pkg::FRAME_DEPTH);
    end
    return sum[afg_pkg::PTR_W-1:0];
  endfunction

  function automatic afg_pkg::ptr_t next_addr(afg_pkg::ptr_t a);
    return (a == afg_pkg::PTR_W'(afg_pkg::FRAME_DEPTH - 1)) ? '0 : a + afg_pkg::PTR_W'(1);
  endfunction

  assign acc       = req_i.valid && req_i.ready;
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign two_lanes = (afg_pkg::MAX_CHANNELS > 1) && (chan_q != afg_pkg::CHAN_W'(0))
                     && (chan_q != afg_pkg::CHAN_W'(1));
  assign full      = held_q == afg_pkg::CNT_W'(afg_pkg::FRAME_DEPTH);
  assign n_ext     = afg_pkg::CMP_W'(req_i.frame_count);
  assign held_ext  = afg_pkg::CMP_W'(held_q);
  assign pop_bad   = (n_ext > afg_pkg::CMP_W'(afg_pkg::MAX_BURST)) || (n_ext > held_ext);
  assign zero_bad  = (n_ext > afg_pkg::CMP_W'(afg_pkg::MAX_BURST))
                     || (n_ext + held_ext > afg_pkg::CMP_W'(afg_pkg::FRAME_DEPTH));
  assign push_slot = wrap_add(rp_q, held_q);
  assign pop_end   = wrap_add(rp_q, afg_pkg::CNT_W'(req_i.frame_count));

  // Gain lanes for scale and pan
  afg_gain u_gain0 (
    .clk_i    (clk_i),
    .sample_i (rdata_q[afg_pkg::SAMPLE_W-1:0]),
    .gain_i   (gain0_q),
    .sample_o (g0)
  );

  afg_gain u_gain1 (
    .clk_i    (clk_i),
    .sample_i (rdata_q[afg_pkg::WORD_W-1 -: afg_pkg::SAMPLE_W]),
    .gain_i   (gain1_q),
    .sample_o (g1)
  );

  // Frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afg_pkg::S_IDLE: begin
        if (acc) begin
          case (req_i.operation)
            afg_pkg::OP_POP: begin
              state_d = (req_i.frame_count == '0 || pop_bad) ? afg_pkg::S_RESP
                                                              : afg_pkg::S_POP_RD;
            end
            afg_pkg::OP_ZERO: begin
              state_d = (req_i.frame_count == '0 || zero_bad) ? afg_pkg::S_RESP
                                                               : afg_pkg::S_ZERO;
            end
            afg_pkg::OP_SCALE: begin
              state_d = (held_q == '0) ? afg_pkg::S_RESP : afg_pkg::S_WALK;
            end
            afg_pkg::OP_PAN: begin
              state_d = (held_q == '0 || !two_lanes) ? afg_pkg::S_RESP : afg_pkg::S_WALK;
            end
            default: begin
              state_d = afg_pkg::S_RESP;
            end
          endcase
        end
      end
      afg_pkg::S_ZERO: begin
        if (cnt_q == afg_pkg::CNT_W'(1)) begin
          state_d = afg_pkg::S_RESP;
        end
      end
      afg_pkg::S_POP_RD: begin
        state_d = afg_pkg::S_POP_OUT;
      end
      afg_pkg::S_POP_OUT: begin
        if (out_free) begin
          state_d = (cnt_q == afg_pkg::CNT_W'(1)) ? afg_pkg::S_IDLE : afg_pkg::S_POP_RD;
        end
      end
      afg_pkg::S_WALK: begin
        if (cnt_q == '0 && !rd_v_q && !prod_v_q) begin
          state_d = afg_pkg::S_RESP;
        end
      end
      afg_pkg::S_RESP: begin
        if (out_free) begin
          state_d = afg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = afg_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: store port controls and result load
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    out_load    = 1'b0;
    out_s0      = '0;
    out_s1      = '0;
    out_status  = afg_pkg::STAT_OK;
    out_last    = 1'b1;
    case (state_q)
      afg_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (acc && req_i.operation == afg_pkg::OP_PUSH && !full) begin
          mem_we    = 1'b1;
          mem_waddr = push_slot;
          mem_wdata = {(two_lanes ? req_i.sample_1 : afg_pkg::sample_t'(0)), req_i.sample_0};
        end
      end
      afg_pkg::S_ZERO: begin
        mem_we = 1'b1;
      end
      afg_pkg::S_POP_RD: begin
        mem_re = 1'b1;
      end
      afg_pkg::S_POP_OUT: begin
        out_load = out_free;
        out_s0   = rdata_q[afg_pkg::SAMPLE_W-1:0];
        out_s1   = two_lanes ? rdata_q[afg_pkg::WORD_W-1 -: afg_pkg::SAMPLE_W] : '0;
        out_last = cnt_q == afg_pkg::CNT_W'(1);
      end
      afg_pkg::S_WALK: begin
        mem_re    = cnt_q != '0;
        mem_we    = prod_v_q;
        mem_waddr = a2_q;
        mem_wdata = {(lane1_en_q ? g1 : old_q[afg_pkg::WORD_W-1 -: afg_pkg::SAMPLE_W]), g0};
      end
      afg_pkg::S_RESP: begin
        out_load   = out_free;
        out_status = status_q;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= afg_pkg::S_IDLE;
      chan_q     <= afg_pkg::CHAN_RESET;
      rp_q       <= '0;
      held_q     <= '0;
      cnt_q      <= '0;
      addr_q     <= '0;
      status_q   <= afg_pkg::STAT_OK;
      lane1_en_q <= 1'b0;
      rd_v_q     <= 1'b0;
      prod_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= (state_q == afg_pkg::S_WALK) && (cnt_q != '0);
      prod_v_q <= rd_v_q;
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      case (state_q)
        afg_pkg::S_IDLE: begin
          if (acc) begin
            case (req_i.operation)
              afg_pkg::OP_PUSH: begin
                if (full) begin
                  status_q <= afg_pkg::STAT_OVF;
                end else begin
                  status_q <= afg_pkg::STAT_OK;
                  held_q   <= held_q + afg_pkg::CNT_W'(1);
                end
              end
              afg_pkg::OP_POP: begin
                if (req_i.frame_count == '0) begin
                  status_q <= afg_pkg::STAT_OK;
                end else if (pop_bad) begin
                  status_q <= afg_pkg::STAT_SHORT;
                end else begin
                  status_q <= afg_pkg::STAT_OK;
                  addr_q   <= rp_q;
                  cnt_q    <= afg_pkg::CNT_W'(req_i.frame_count);
                  rp_q     <= pop_end;
                  held_q   <= held_q - afg_pkg::CNT_W'(req_i.frame_count);
                end
              end
              afg_pkg::OP_ZERO: begin
                if (zero_bad) begin
                  status_q <= afg_pkg::STAT_OVF;
                end else begin
                  status_q <= afg_pkg::STAT_OK;
                  addr_q   <= push_slot;
                  cnt_q    <= afg_pkg::CNT_W'(req_i.frame_count);
                end
              end
              afg_pkg::OP_SCALE, afg_pkg::OP_PAN: begin
                status_q   <= afg_pkg::STAT_OK;
                addr_q     <= rp_q;
                cnt_q      <= held_q;
                lane1_en_q <= two_lanes;
              end
              afg_pkg::OP_FLUSH: begin
                status_q <= afg_pkg::STAT_OK;
                rp_q     <= '0;
                held_q   <= '0;
              end
              default: begin
                status_q <= afg_pkg::STAT_OK;
              end
            endcase
          end
        end
        afg_pkg::S_ZERO: begin
          held_q <= held_q + afg_pkg::CNT_W'(1);
          addr_q <= next_addr(addr_q);
          cnt_q  <= cnt_q - afg_pkg::CNT_W'(1);
        end
        afg_pkg::S_POP_OUT: begin
          if (out_free) begin
            addr_q <= next_addr(addr_q);
            cnt_q  <= cnt_q - afg_pkg::CNT_W'(1);
          end
        end
        afg_pkg::S_WALK: begin
          if (cnt_q != '0) begin
            addr_q <= next_addr(addr_q);
            cnt_q  <= cnt_q - afg_pkg::CNT_W'(1);
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // Gains and walk addresses, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == afg_pkg::S_IDLE && acc) begin
      gain0_q <= req_i.gain_left;
      gain1_q <= (req_i.operation == afg_pkg::OP_PAN) ? req_i.gain_right : req_i.gain_left;
    end
    a1_q  <= addr_q;
    a2_q  <= a1_q;
    old_q <= rdata_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Fill level is captured with the result so it holds while the result waits
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_s0_q     <= out_s0;
      rsp_s1_q     <= out_s1;
      rsp_status_q <= out_status;
      rsp_last_q   <= out_last;
      rsp_fill_q   <= afg_pkg::FILL_W'(held_q);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.out_sample_0 = rsp_s0_q;
  assign rsp_o.out_sample_1 = rsp_s1_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.last         = rsp_last_q;
  assign rsp_o.fill_level   = rsp_fill_q;

`ifndef SYNTHESIS
  // Fill count never exceeds the store
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_ext <= afg_pkg::CMP_W'(afg_pkg::FRAME_DEPTH))
    else $error("fill count above store depth");

  // Only a successful pop gives a result that is not last
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_last_q) |-> (rsp_status_q == afg_pkg::STAT_OK))
    else $error("non-final result with error status");

  // Store is not written while a pop reads it
  a_pop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afg_pkg::S_POP_RD || state_q == afg_pkg::S_POP_OUT) |-> !mem_we)
    else $error("store written during pop");

  // Gain pipeline has drained before the final result
  a_walk_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afg_pkg::S_RESP) |-> (!rd_v_q && !prod_v_q))
    else $error("gain pipeline busy at result");
`endif

endmodule

`default_nettype wire
